### rtl/core/ght_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table: table
// geometry, operation and status codes, the control state and the layout
// of one slot entry.
// ----------------------------------------------------------------------------
package ght_pkg;

    // Table geometry
    localparam int SLOTS        = 1024;
    localparam int MASK_BITS    = 32;
    localparam int VERSION_BITS = 32;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Port field widths
    localparam int OP_W     = 3;
    localparam int HIDX_W   = 10;
    localparam int HVER_W   = 32;
    localparam int BITNUM_W = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_TEST  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STALE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd3;

    // Control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    // One slot of the slot memory
    typedef struct packed {
        logic                    live;
        logic [MASK_BITS-1:0]    mask;
        logic [VERSION_BITS-1:0] version;
    } t_slot_entry;

endpackage
`default_nettype wire

### rtl/core/generational_handle_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// Handle allocator with a version number and an attribute mask per slot.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An item is taken in the idle state,
// the slot memory and the free-stack memory are read at that edge, and the
// execute state then checks the handle, writes the slot back and loads the
// result register once the output is free. An allocate that pops the free
// stack needs a second, dependent read of the popped slot's entry in the pop
// state. The slot memory read is registered. The result register lets a new
// item be taken while the previous result still waits at the output. No
// clearing pass runs after reset: the used-slot count marks which entries
// have ever been written.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Input channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [ght_pkg::OP_W-1:0]       i_operation,
    input  wire  [ght_pkg::HIDX_W-1:0]     i_handle_index,
    input  wire  [ght_pkg::HVER_W-1:0]     i_handle_version,
    input  wire  [ght_pkg::BITNUM_W-1:0]   i_bit_number,
    // Output channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [ght_pkg::STATUS_W-1:0]   o_status,
    output logic [ght_pkg::HIDX_W-1:0]     o_out_index,
    output logic [ght_pkg::HVER_W-1:0]     o_out_version,
    output logic                           o_bit_value
);

    localparam int IDX_W = ght_pkg::IDX_W;
    localparam int CNT_W = ght_pkg::CNT_W;
    localparam int MB    = ght_pkg::MASK_BITS;
    localparam int VB    = ght_pkg::VERSION_BITS;

    // Memories
    ght_pkg::t_slot_entry r_slot_mem [ght_pkg::SLOTS];
    logic [IDX_W-1:0]     r_stk_mem  [ght_pkg::SLOTS];

    // Control and counters
    ght_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [CNT_W-1:0] r_used_slots, n_used_slots;

    // Captured item
    logic [ght_pkg::OP_W-1:0]     r_op;
    logic [ght_pkg::HIDX_W-1:0]   r_idx;
    logic [ght_pkg::HVER_W-1:0]   r_ver;
    logic [ght_pkg::BITNUM_W-1:0] r_bit;

    // Read data
    ght_pkg::t_slot_entry r_slot_q;
    logic [IDX_W-1:0]     r_stk_q;

    // Result register
    logic                          r_out_valid;
    logic [ght_pkg::STATUS_W-1:0]  r_status;
    logic [ght_pkg::HIDX_W-1:0]    r_out_idx;
    logic [ght_pkg::HVER_W-1:0]    r_out_ver;
    logic                          r_bit_val;

    // Datapath controls
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_slot_rd_en;
    logic [IDX_W-1:0]              w_slot_rd_addr;
    logic                          w_slot_we;
    logic [IDX_W-1:0]              w_slot_wa;
    ght_pkg::t_slot_entry          w_slot_wd;
    logic                          w_stk_we;
    logic [IDX_W-1:0]              w_stk_wa;
    logic [IDX_W-1:0]              w_stk_wd;
    logic                          w_res_load;
    logic [ght_pkg::STATUS_W-1:0]  w_res_status;
    logic [ght_pkg::HIDX_W-1:0]    w_res_idx;
    logic [ght_pkg::HVER_W-1:0]    w_res_ver;
    logic                          w_res_bit;

    // Handle check and bit select
    logic [CNT_W-1:0]  w_top;
    logic              w_idx_ok;
    logic              w_ver_ok;
    logic              w_bit_in_range;
    logic [MB-1:0]     w_sel;
    logic              w_pop;

    assign o_in_ready = (r_state == ght_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_top    = r_free_count - CNT_W'(1);
    assign w_idx_ok = CNT_W'(r_idx) < r_used_slots;
    assign w_ver_ok = r_slot_q.live && (r_ver == ght_pkg::HVER_W'(r_slot_q.version));
    assign w_bit_in_range = 32'(r_bit) < MB;
    assign w_sel    = w_bit_in_range ? (MB'(1) << r_bit) : '0;
    assign w_pop    = (r_op == ght_pkg::OP_ALLOC) && (r_free_count != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ght_pkg::S_IDLE: begin
                if (w_accept) n_state = ght_pkg::S_EXEC;
            end
            ght_pkg::S_EXEC: begin
                if (w_pop) begin
                    n_state = ght_pkg::S_POP;
                end else if (w_out_free) begin
                    n_state = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_POP: begin
                if (w_out_free) n_state = ght_pkg::S_IDLE;
            end
            default: n_state = ght_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, counter updates and result values
    always_comb begin
        w_slot_rd_en   = 1'b0;
        w_slot_rd_addr = IDX_W'(i_handle_index);
        w_slot_we      = 1'b0;
        w_slot_wa      = IDX_W'(r_idx);
        w_slot_wd      = r_slot_q;
        w_stk_we       = 1'b0;
        w_stk_wa       = r_free_count[IDX_W-1:0];
        w_stk_wd       = IDX_W'(r_idx);
        w_res_load     = 1'b0;
        w_res_status   = ght_pkg::ST_OK;
        w_res_idx      = '0;
        w_res_ver      = '0;
        w_res_bit      = 1'b0;
        n_free_count   = r_free_count;
        n_used_slots   = r_used_slots;
        unique case (r_state)
            ght_pkg::S_IDLE: begin
                // Read the addressed slot and the stack top with the transfer
                w_slot_rd_en = w_accept;
            end
            ght_pkg::S_EXEC: begin
                if (w_pop) begin
                    // Read the entry of the popped slot
                    w_slot_rd_en   = 1'b1;
                    w_slot_rd_addr = r_stk_q;
                end else if (w_out_free) begin
                    w_res_load = 1'b1;
                    if (r_op == ght_pkg::OP_ALLOC) begin
                        // Take the next never-used slot, or report full
                        if (r_used_slots < CNT_W'(ght_pkg::SLOTS)) begin
                            w_slot_we         = 1'b1;
                            w_slot_wa         = r_used_slots[IDX_W-1:0];
                            w_slot_wd.live    = 1'b1;
                            w_slot_wd.mask    = '0;
                            w_slot_wd.version = '0;
                            w_res_idx         = ght_pkg::HIDX_W'(r_used_slots[IDX_W-1:0]);
                            n_used_slots      = r_used_slots + CNT_W'(1);
                        end else begin
                            w_res_status = ght_pkg::ST_FULL;
                        end
                    end else if (r_op == ght_pkg::OP_FREE || r_op == ght_pkg::OP_SET ||
                                 r_op == ght_pkg::OP_CLEAR || r_op == ght_pkg::OP_TEST) begin
                        if (!w_idx_ok) begin
                            w_res_status = ght_pkg::ST_UNALLOC;
                        end else if (!w_ver_ok) begin
                            w_res_status = ght_pkg::ST_STALE;
                        end else if (r_op == ght_pkg::OP_FREE) begin
                            // Bump the version, drop the mask, push the slot
                            w_slot_we         = 1'b1;
                            w_slot_wd.live    = 1'b0;
                            w_slot_wd.mask    = '0;
                            w_slot_wd.version = r_slot_q.version + VB'(1);
                            if (r_free_count < CNT_W'(ght_pkg::SLOTS)) begin
                                w_stk_we     = 1'b1;
                                n_free_count = r_free_count + CNT_W'(1);
                            end
                        end else if (r_op == ght_pkg::OP_SET) begin
                            w_slot_we      = 1'b1;
                            w_slot_wd.mask = r_slot_q.mask | w_sel;
                        end else if (r_op == ght_pkg::OP_CLEAR) begin
                            w_slot_we      = 1'b1;
                            w_slot_wd.mask = r_slot_q.mask & ~w_sel;
                        end else begin
                            w_res_bit = |(r_slot_q.mask & w_sel);
                        end
                    end
                end
            end
            ght_pkg::S_POP: begin
                // Revive the popped slot with its stored version
                if (w_out_free) begin
                    w_res_load     = 1'b1;
                    w_slot_we      = 1'b1;
                    w_slot_wa      = r_stk_q;
                    w_slot_wd.live = 1'b1;
                    w_slot_wd.mask = '0;
                    w_res_idx      = ght_pkg::HIDX_W'(r_stk_q);
                    w_res_ver      = ght_pkg::HVER_W'(r_slot_q.version);
                    n_free_count   = w_top;
                end
            end
            default: begin
                w_res_load = 1'b0;
            end
        endcase
    end

    // Slot memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) r_slot_mem[w_slot_wa] <= w_slot_wd;
        if (w_slot_rd_en) r_slot_q <= r_slot_mem[w_slot_rd_addr];
    end

    // Free-stack memory
    always_ff @(posedge i_clk) begin
        if (w_stk_we) r_stk_mem[w_stk_wa] <= w_stk_wd;
        if (w_accept) r_stk_q <= r_stk_mem[w_top[IDX_W-1:0]];
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_idx <= i_handle_index;
            r_ver <= i_handle_version;
            r_bit <= i_bit_number;
        end
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ght_pkg::S_IDLE;
            r_free_count <= '0;
            r_used_slots <= '0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_used_slots <= n_used_slots;
        end
    end

    // Result register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status  <= w_res_status;
            r_out_idx <= w_res_idx;
            r_out_ver <= w_res_ver;
            r_bit_val <= w_res_bit;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_index   = r_out_idx;
    assign o_out_version = r_out_ver;
    assign o_bit_value   = r_bit_val;

endmodule
`default_nettype wire
